FILE: rtl/pms_pkg.sv
// ----------------------------------------------------------------------------
// Partitioned multi-stack package
// Beat types, configuration register codes, control and status bundles.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int unsigned CNT_W  = 4;   // stack_count and stack_number width
  localparam int unsigned SECT_W = 9;   // section_size, total_length, fill width
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic signed [DATA_W-1:0] POP_FAIL_VALUE = -32'sd1;

  localparam logic [CNT_W-1:0]  RST_STACK_COUNT  = 4'd4;
  localparam logic [SECT_W-1:0] RST_SECTION_SIZE = 9'd2;
  localparam logic [SECT_W-1:0] RST_TOTAL_LENGTH = 9'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STACK_COUNT  = 2'd0,
    CFG_SECTION_SIZE = 2'd1,
    CFG_TOTAL_LENGTH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                     command;
    logic [CNT_W-1:0]         stack_number;
    logic signed [DATA_W-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic                     success;
    logic signed [DATA_W-1:0] popped_value;
  } out_beat_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [SECT_W-1:0]    wdata;
  } cfg_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FETCH  = 2'd1,
    ST_EXEC   = 2'd2,
    ST_RESULT = 2'd3
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic fetch;
    logic exec;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/pms_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One beat moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface pms_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/partitioned_multi_stack.sv
// ----------------------------------------------------------------------------
// Partitioned multi-stack
// Several LIFO stacks in one shared memory split into fixed sections.
// ----------------------------------------------------------------------------
// Each input beat pushes onto or pops from one stack and yields exactly one
// result beat, going through the fill count RAM read, section base multiply,
// data RAM access and result load in order; the load waits for a free output
// register, and the next beat is accepted after the load while the result
// sits there. Fill counts start empty after reset through per-stack valid
// bits, so no clearing pass is needed. Configuration writes are taken at any
// time and must only be issued while the block is idle.
module partitioned_multi_stack #(
  parameter int unsigned MAX_STACKS = 8,
  parameter int unsigned MEM_DEPTH  = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pms_stream_if.sink   in_i,
  pms_stream_if.source out_o,
  pms_stream_if.sink   cfg_i
);

  pms_pkg::ctrl_cmd_t  cmd;
  pms_pkg::dp_status_t stat;

  pms_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  pms_datapath #(
    .MAX_STACKS (MAX_STACKS),
    .MEM_DEPTH  (MEM_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while previous beat in flight");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> stat.out_free)
    else $error("result loaded over a pending result");

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.load))
    else $error("result valid without a load");

endmodule

FILE: rtl/pms_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held between reads.
// ----------------------------------------------------------------------------
module pms_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pms_ctrl.sv
// ----------------------------------------------------------------------------
// Partitioned multi-stack controller
// Sequences accept, fill fetch, memory access and result load per beat.
// ----------------------------------------------------------------------------
module pms_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pms_pkg::dp_status_t   stat_i,
  output pms_pkg::ctrl_cmd_t    cmd_o
);

  pms_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pms_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      pms_pkg::ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (stat_i.in_valid) begin
          cmd_o.accept = 1'b1;
          state_d      = pms_pkg::ST_FETCH;
        end
      end
      pms_pkg::ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = pms_pkg::ST_EXEC;
      end
      pms_pkg::ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = pms_pkg::ST_RESULT;
      end
      pms_pkg::ST_RESULT: begin
        // hold until the output register frees up
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = pms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pms_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/pms_datapath.sv
// ----------------------------------------------------------------------------
// Partitioned multi-stack datapath
// Configuration registers, fill counts, shared data memory, result register.
// ----------------------------------------------------------------------------
module pms_datapath #(
  parameter int unsigned MAX_STACKS = 8,
  parameter int unsigned MEM_DEPTH  = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pms_stream_if.sink            in_i,
  pms_stream_if.source          out_o,
  pms_stream_if.sink            cfg_i,
  input  pms_pkg::ctrl_cmd_t    cmd_i,
  output pms_pkg::dp_status_t   stat_o
);

  localparam int unsigned SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam int unsigned LW = (SW + 1 > pms_pkg::CNT_W) ? SW + 1 : pms_pkg::CNT_W;
  localparam int unsigned BW = SW + pms_pkg::SECT_W;
  localparam int unsigned EW = (BW + 1 > AW + 1) ? BW + 1 : AW + 1;
  localparam int unsigned FW = pms_pkg::SECT_W;
  localparam int unsigned DW = pms_pkg::DATA_W;

  // configuration
  logic [pms_pkg::CNT_W-1:0]  stack_count_q;
  logic [pms_pkg::SECT_W-1:0] section_size_q;
  logic [pms_pkg::SECT_W-1:0] total_length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_count_q  <= pms_pkg::RST_STACK_COUNT;
      section_size_q <= pms_pkg::RST_SECTION_SIZE;
      total_length_q <= pms_pkg::RST_TOTAL_LENGTH;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        pms_pkg::CFG_STACK_COUNT:  stack_count_q  <= cfg_i.data.wdata[pms_pkg::CNT_W-1:0];
        pms_pkg::CFG_SECTION_SIZE: section_size_q <= cfg_i.data.wdata;
        pms_pkg::CFG_TOTAL_LENGTH: total_length_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // accept stage: decode stack number
  logic [LW-1:0] number_ext, limit, slot_full;
  logic          bad_d;

  assign number_ext = LW'(in_i.data.stack_number);
  assign limit      = (LW'(stack_count_q) < LW'(MAX_STACKS)) ? LW'(stack_count_q)
                                                             : LW'(MAX_STACKS);
  assign bad_d      = (number_ext == '0) || (number_ext > limit);
  assign slot_full  = number_ext - LW'(1);

  assign in_i.ready      = cmd_i.in_ready;
  assign stat_o.in_valid = in_i.valid;

  logic                    is_pop_q, bad_q, last_q;
  logic [SW-1:0]           slot_q;
  logic [DW-1:0]           value_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      is_pop_q <= (in_i.data.command == pms_pkg::CMD_POP);
      bad_q    <= bad_d;
      last_q   <= (in_i.data.stack_number == stack_count_q);
      slot_q   <= slot_full[SW-1:0];
      value_q  <= in_i.data.push_value;
    end
  end

  // fill counts: RAM plus per-stack valid bits cleared by reset
  logic [MAX_STACKS-1:0] fill_vld_q;
  logic [FW-1:0]         fill_rdata, fill_wdata;
  logic                  fill_we;

  pms_ram #(.WIDTH(FW), .DEPTH(MAX_STACKS)) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_we),
    .waddr_i (slot_q),
    .wdata_i (fill_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (slot_full[SW-1:0]),
    .rdata_o (fill_rdata)
  );

  // fetch stage: section base and current fill
  logic [BW-1:0] base_q;
  logic [FW-1:0] fill_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      base_q <= BW'(slot_q) * BW'(section_size_q);
      fill_q <= fill_vld_q[slot_q] ? fill_rdata : '0;
    end
  end

  // exec stage: bounds, memory access, fill update
  logic [BW-1:0] cap;
  logic [EW-1:0] push_addr, pop_addr;
  logic          push_ok, pop_ok, pop_in_range;
  logic [AW-1:0] mem_addr;
  logic [DW-1:0] mem_rdata;

  always_comb begin
    if (last_q) begin
      cap = (BW'(total_length_q) > base_q) ? BW'(total_length_q) - base_q : '0;
    end else begin
      cap = BW'(section_size_q);
    end
    push_addr    = EW'(base_q) + EW'(fill_q);
    pop_addr     = push_addr - EW'(1);
    push_ok      = !is_pop_q && !bad_q && (BW'(fill_q) < cap)
                   && (push_addr < EW'(MEM_DEPTH));
    pop_ok       = is_pop_q && !bad_q && (fill_q != '0);
    pop_in_range = pop_addr < EW'(MEM_DEPTH);
    mem_addr     = is_pop_q ? pop_addr[AW-1:0] : push_addr[AW-1:0];
    fill_we      = cmd_i.exec && (push_ok || pop_ok);
    fill_wdata   = is_pop_q ? fill_q - FW'(1) : fill_q + FW'(1);
  end

  pms_ram #(.WIDTH(DW), .DEPTH(MEM_DEPTH)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec && push_ok),
    .waddr_i (mem_addr),
    .wdata_i (value_q),
    .re_i    (cmd_i.exec && pop_ok && pop_in_range),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
    end else if (fill_we) begin
      fill_vld_q[slot_q] <= 1'b1;
    end
  end

  logic success_q, zero_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      success_q <= push_ok || pop_ok;
      zero_q    <= !pop_in_range;
    end
  end

  // output register
  logic               out_valid_q;
  pms_pkg::out_beat_t out_data_q, out_data_d;

  always_comb begin
    out_data_d.success = success_q;
    if (!is_pop_q) begin
      out_data_d.popped_value = '0;
    end else if (!success_q) begin
      out_data_d.popped_value = pms_pkg::POP_FAIL_VALUE;
    end else if (zero_q) begin
      out_data_d.popped_value = '0;
    end else begin
      out_data_d.popped_value = mem_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.data      = out_data_q;
  assign stat_o.out_free = !out_valid_q || out_o.ready;

endmodule
